// ===== hdl/assert_macros.svh =====
// assertion helpers used by the checker file
// they expect signals named clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/brsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brsc_pkg
// shared widths, constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package brsc_pkg;

    localparam int CAP_W      = 13;
    localparam int START_W    = 12;
    localparam int COUNT_W    = 13;
    localparam int IDX_OUT_W  = 6;
    localparam int VALUE_W    = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic issue;
        logic step;
        logic push_reject;
    } ctrl_cmd_t;

    typedef struct packed {
        logic reject;
        logic touched;
        logic word_last;
        logic s1_valid;
        logic s1_adv;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/brsc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brsc_datapath
// request registers, word scan, bitmap memory, masking stage and result register
// ----------------------------------------------------------------------------
module brsc_datapath
    import brsc_pkg::*;
#(
    parameter int WORD_COUNT = 64,
    parameter int WORD_BITS  = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CAP_W-1:0]      cfg_wr_data,
    input  logic                  op,
    input  logic [START_W-1:0]    start_bit,
    input  logic [COUNT_W-1:0]    bit_count,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [IDX_OUT_W-1:0]  word_index,
    output logic [VALUE_W-1:0]    word_value,
    output logic                  overflow,
    output logic                  last,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status
);

    localparam int IDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int OFF_W = $clog2(WORD_BITS);
    localparam logic [CAP_W-1:0] CAP_TOTAL = CAP_W'(WORD_COUNT * WORD_BITS);
    localparam logic [CAP_W-1:0] WORD_STEP = CAP_W'(WORD_BITS);
    localparam logic [OFF_W-1:0] OFF_MAX   = OFF_W'(WORD_BITS - 1);

    // configuration
    logic [CAP_W-1:0] cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    // request
    logic               op_reg;
    logic [START_W-1:0] start_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [CAP_W-1:0]   final_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op;
            start_reg <= start_bit;
            count_reg <= bit_count;
            final_reg <= CAP_W'({1'b0, start_bit}) + bit_count - CAP_W'(1);
        end
    end

    logic [CAP_W-1:0] cap_eff;
    logic [CAP_W:0]   end_sum;

    always_comb
    begin
        cap_eff = (cap_reg > CAP_TOTAL) ? CAP_TOTAL : cap_reg;
        end_sum = (CAP_W+1)'(start_reg) + (CAP_W+1)'(count_reg);
    end

    // word scan
    logic [IDX_W-1:0] q_reg;
    logic [CAP_W-1:0] base_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            q_reg    <= '0;
            base_reg <= '0;
        end
        else if (cmd.step)
        begin
            q_reg    <= q_reg + IDX_W'(1);
            base_reg <= base_reg + WORD_STEP;
        end
    end

    logic [CAP_W-1:0] word_end;
    logic [CAP_W-1:0] lo_diff;
    logic [CAP_W-1:0] hi_diff;
    logic [OFF_W-1:0] lo_now;
    logic [OFF_W-1:0] hi_now;
    logic             touched;
    logic             word_last;

    always_comb
    begin
        word_end  = base_reg + WORD_STEP - CAP_W'(1);
        touched   = word_end >= CAP_W'(start_reg);
        word_last = final_reg <= word_end;
        lo_diff   = CAP_W'(start_reg) - base_reg;
        hi_diff   = final_reg - base_reg;
        lo_now    = (CAP_W'(start_reg) > base_reg) ? lo_diff[OFF_W-1:0] : '0;
        hi_now    = word_last ? hi_diff[OFF_W-1:0] : OFF_MAX;
    end

    // bitmap memory, entry valid bits stand for the all-zero reset
    logic [WORD_BITS-1:0]  mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] vld_reg;
    logic [WORD_BITS-1:0]  rd_data_reg;
    logic                  rd_vld_reg;

    // read stage
    logic             s1_valid_reg;
    logic [IDX_W-1:0] s1_q_reg;
    logic [OFF_W-1:0] s1_lo_reg;
    logic [OFF_W-1:0] s1_hi_reg;
    logic             s1_last_reg;

    logic out_valid_reg;
    logic out_free;
    logic s1_adv;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_data_reg <= mem[q_reg];
            rd_vld_reg  <= vld_reg[q_reg];
            s1_q_reg    <= q_reg;
            s1_lo_reg   <= lo_now;
            s1_hi_reg   <= hi_now;
            s1_last_reg <= word_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.issue)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // modify stage
    logic [WORD_BITS-1:0] full_word;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] old_word;
    logic [WORD_BITS-1:0] new_word;

    always_comb
    begin
        full_word = '1;
        mask      = (full_word >> (OFF_MAX - s1_hi_reg)) & (full_word << s1_lo_reg);
        old_word  = rd_vld_reg ? rd_data_reg : '0;
        new_word  = op_reg ? (old_word | mask) : (old_word & ~mask);
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            mem[s1_q_reg] <= new_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (s1_adv)
        begin
            vld_reg[s1_q_reg] <= 1'b1;
        end
    end

    // result register
    logic [IDX_OUT_W-1:0] index_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic                 overflow_reg;
    logic                 last_reg;
    logic                 out_load;

    assign out_load = s1_adv || cmd.push_reject;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            index_reg    <= IDX_OUT_W'(s1_q_reg);
            value_reg    <= VALUE_W'(new_word);
            overflow_reg <= 1'b0;
            last_reg     <= s1_last_reg;
        end
        else if (cmd.push_reject)
        begin
            index_reg    <= '0;
            value_reg    <= '0;
            overflow_reg <= 1'b1;
            last_reg     <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign word_index = index_reg;
    assign word_value = value_reg;
    assign overflow   = overflow_reg;
    assign last       = last_reg;

    always_comb
    begin
        status.reject    = (count_reg == '0) || (end_sum > (CAP_W+1)'(cap_eff));
        status.touched   = touched;
        status.word_last = word_last;
        status.s1_valid  = s1_valid_reg;
        status.s1_adv    = s1_adv;
        status.out_free  = out_free;
    end

endmodule

// ===== hdl/brsc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brsc_ctrl
// request sequencer: range check, word scan and read issue, drain
// ----------------------------------------------------------------------------
module brsc_ctrl
    import brsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   can_issue;

    // the read stage is free, or hands its word on this cycle
    assign can_issue = !status.s1_valid || status.s1_adv;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.scan_start = 1'b1;
                if (!status.reject)
                begin
                    state_next = ST_SCAN;
                end
                else if (status.out_free)
                begin
                    cmd.push_reject = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (!status.touched)
                begin
                    cmd.step = 1'b1;
                end
                else if (can_issue)
                begin
                    cmd.issue = 1'b1;
                    cmd.step  = 1'b1;
                    if (status.word_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (can_issue)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/bitmap_range_set_clear_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_range_set_clear_unit
// sets or clears a run of bits in a word bitmap and reports every word it touches
// ----------------------------------------------------------------------------
// One request at a time. After the input transfer the block runs the range check,
// then walks the words from index 0 one per cycle, while the result register takes
// each touched word, up to the last word of the run; words before the run are
// skipped, each touched word is read, masked, written back and handed to the result
// register. A rejected request (empty run or past capacity) gives one overflow
// result. The word read into the masking stage sets the pace of one word per cycle
// while results are taken at once. The bitmap reads as all zero after reset with no
// clearing pass.
module bitmap_range_set_clear_unit
    import brsc_pkg::*;
#(
    parameter int WORD_COUNT = 64,
    parameter int WORD_BITS  = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CAP_W-1:0]      cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    input  logic [START_W-1:0]    start_bit,
    input  logic [COUNT_W-1:0]    bit_count,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [IDX_OUT_W-1:0]  word_index,
    output logic [VALUE_W-1:0]    word_value,
    output logic                  overflow,
    output logic                  last
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    brsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    brsc_datapath #(
        .WORD_COUNT (WORD_COUNT),
        .WORD_BITS  (WORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .op          (op),
        .start_bit   (start_bit),
        .bit_count   (bit_count),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .word_index  (word_index),
        .word_value  (word_value),
        .overflow    (overflow),
        .last        (last),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ===== hdl/brsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brsc_checker
// port-level checks for the bitmap range set/clear unit
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brsc_checker
    import brsc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [IDX_OUT_W-1:0] word_index,
    input logic [VALUE_W-1:0]   word_value,
    input logic                 overflow,
    input logic                 last
);

    // a rejected request ends with its only result
    `ASSERT_IMPL(a_overflow_last, out_valid && overflow, last)

    // a rejected request reports no word
    `ASSERT_IMPL(a_overflow_zero, out_valid && overflow, (word_index == '0) && (word_value == '0))

    // one request at a time: no input transfer right after another
    `ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready)

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(word_value) && $stable(last))

endmodule

bind bitmap_range_set_clear_unit brsc_checker u_brsc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .word_index (word_index),
    .word_value (word_value),
    .overflow   (overflow),
    .last       (last)
);
